### sv/dws_pkg.sv
package dws_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;
  localparam int REQ_W     = 2;
  localparam int LEN_W     = 5;
  localparam int STEP_W    = 3;

  localparam logic [REQ_W-1:0] REQ_FRONT  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BACK   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 2'd2;

  // microprogram addresses
  localparam logic [STEP_W-1:0] STEP_WAIT   = 3'd0;
  localparam logic [STEP_W-1:0] STEP_DISP   = 3'd1;
  localparam logic [STEP_W-1:0] STEP_FRONT  = 3'd2;
  localparam logic [STEP_W-1:0] STEP_BACK   = 3'd3;
  localparam logic [STEP_W-1:0] STEP_SINIT  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_SREAD  = 3'd5;
  localparam logic [STEP_W-1:0] STEP_SDRAIN = 3'd6;
  localparam logic [STEP_W-1:0] STEP_EMIT   = 3'd7;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LATCH,
    OP_DISP,
    OP_WR_FRONT,
    OP_WR_BACK,
    OP_SRCH_INIT,
    OP_SRCH_READ,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_ALWAYS,
    C_ACCEPT,
    C_DISPATCH,
    C_EMPTY,
    C_LAST,
    C_OUT_FREE
  } cond_t;

  typedef struct packed {
    op_t               op;
    cond_t             cond;
    logic [STEP_W-1:0] tgt;   // taken when cond holds
    logic [STEP_W-1:0] alt;   // taken otherwise
  } ctrl_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] pc);
    ctrl_t w;
    begin
      case (pc)
        STEP_WAIT:   w = '{OP_LATCH,     C_ACCEPT,   STEP_DISP,   STEP_WAIT};
        STEP_DISP:   w = '{OP_DISP,      C_DISPATCH, STEP_EMIT,   STEP_EMIT};
        STEP_FRONT:  w = '{OP_WR_FRONT,  C_ALWAYS,   STEP_EMIT,   STEP_EMIT};
        STEP_BACK:   w = '{OP_WR_BACK,   C_ALWAYS,   STEP_EMIT,   STEP_EMIT};
        STEP_SINIT:  w = '{OP_SRCH_INIT, C_EMPTY,    STEP_EMIT,   STEP_SREAD};
        STEP_SREAD:  w = '{OP_SRCH_READ, C_LAST,     STEP_SDRAIN, STEP_SREAD};
        STEP_SDRAIN: w = '{OP_NOP,       C_ALWAYS,   STEP_EMIT,   STEP_EMIT};
        STEP_EMIT:   w = '{OP_EMIT,      C_OUT_FREE, STEP_WAIT,   STEP_EMIT};
        default:     w = '{OP_NOP,       C_ALWAYS,   STEP_WAIT,   STEP_WAIT};
      endcase
      return w;
    end
  endfunction

endpackage

### sv/dws_if.sv
interface dws_in_if;
  logic                              valid;
  logic                              ready;
  logic [dws_pkg::REQ_W-1:0]         req_type;
  logic signed [dws_pkg::VAL_W-1:0]  value;

  modport source (output valid, output req_type, output value, input ready);
  modport sink   (input valid, input req_type, input value, output ready);
endinterface

interface dws_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic                      rejected;
  logic [dws_pkg::LEN_W-1:0] length;

  modport source (output valid, output found, output rejected, output length, input ready);
  modport sink   (input valid, input found, input rejected, input length, output ready);
endinterface

### sv/deque_with_search_unit.sv
// channel   | dir | handshake          | payload
// ----------+-----+--------------------+-----------------------------------
// in_req    | in  | valid/ready        | req_type[1:0], value[31:0] signed
// out_rsp   | out | valid/ready        | found, rejected, length[4:0]
//
// One request at a time, run by an 8-step microprogram.
// Insert: DISP, FRONT or BACK, then EMIT loads the result; a rejected insert or
// unused code goes from DISP to EMIT. Search: SINIT, an SREAD per entry, SDRAIN,
// EMIT (or SINIT to EMIT if empty); one read port: one entry compared per cycle.
// rst_n (sync, active low) empties the deque; stored values are not cleared.
// The result register holds while out_rsp.ready is low; a new request is taken
// as soon as the previous result is loaded there.
module deque_with_search_unit #(
  parameter int DEPTH = dws_pkg::DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dws_in_if.sink     in_req,
  dws_out_if.source  out_rsp
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [dws_pkg::STEP_W-1:0]       pc_r, pc_nxt;
  logic [dws_pkg::REQ_W-1:0]        req_r, req_nxt;
  logic signed [dws_pkg::VAL_W-1:0] value_r, value_nxt;
  logic [AW-1:0]                    head_r, head_nxt;
  logic [CW-1:0]                    count_r, count_nxt;
  logic [AW-1:0]                    ptr_r, ptr_nxt;
  logic [CW-1:0]                    k_r, k_nxt;
  logic                             rd_valid_r, rd_valid_nxt;
  logic                             found_r, found_nxt;
  logic                             rej_r, rej_nxt;
  logic                             out_valid_r, out_valid_nxt;
  logic                             out_found_r, out_found_nxt;
  logic                             out_rej_r, out_rej_nxt;
  logic [dws_pkg::LEN_W-1:0]        out_len_r, out_len_nxt;

  logic [dws_pkg::VAL_W-1:0] mem [DEPTH];
  logic [dws_pkg::VAL_W-1:0] rd_data_r;

  dws_pkg::ctrl_t             cw;
  logic                       in_acc;
  logic                       out_free;
  logic                       full;
  logic                       is_insert;
  logic                       cond_ok;
  logic [dws_pkg::STEP_W-1:0] disp_tgt;
  logic [AW-1:0]              head_dec;
  logic [AW:0]                back_sum;
  logic [AW-1:0]              back_slot;
  logic [AW-1:0]              ptr_inc;
  logic [CW-1:0]              k_inc;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic                       rd_en;

  assign cw        = dws_pkg::ucode(pc_r);
  assign in_req.ready = (cw.op == dws_pkg::OP_LATCH);
  assign in_acc    = in_req.valid && in_req.ready;
  assign out_free  = !out_valid_r || out_rsp.ready;
  assign full      = (count_r == CW'(DEPTH));
  assign is_insert = req_r inside {dws_pkg::REQ_FRONT, dws_pkg::REQ_BACK};

  assign head_dec  = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
  // count is below DEPTH when an insert gets here, so one subtract wraps it
  assign back_sum  = {1'b0, head_r} + (AW+1)'(count_r);
  assign back_slot = (back_sum >= (AW+1)'(DEPTH)) ? AW'(back_sum - (AW+1)'(DEPTH))
                                                  : back_sum[AW-1:0];
  assign ptr_inc   = (ptr_r == AW'(DEPTH - 1)) ? '0 : ptr_r + 1'b1;
  assign k_inc     = k_r + 1'b1;

  assign wr_en   = (cw.op == dws_pkg::OP_WR_FRONT) || (cw.op == dws_pkg::OP_WR_BACK);
  assign wr_addr = (cw.op == dws_pkg::OP_WR_FRONT) ? head_dec : back_slot;
  assign rd_en   = (cw.op == dws_pkg::OP_SRCH_READ);

  always_comb begin
    case (req_r)
      dws_pkg::REQ_FRONT:  disp_tgt = full ? dws_pkg::STEP_EMIT : dws_pkg::STEP_FRONT;
      dws_pkg::REQ_BACK:   disp_tgt = full ? dws_pkg::STEP_EMIT : dws_pkg::STEP_BACK;
      dws_pkg::REQ_SEARCH: disp_tgt = dws_pkg::STEP_SINIT;
      default:             disp_tgt = dws_pkg::STEP_EMIT;
    endcase
  end

  always_comb begin
    case (cw.cond)
      dws_pkg::C_ALWAYS:   cond_ok = 1'b1;
      dws_pkg::C_ACCEPT:   cond_ok = in_acc;
      dws_pkg::C_EMPTY:    cond_ok = (count_r == '0);
      dws_pkg::C_LAST:     cond_ok = (k_inc == count_r);
      dws_pkg::C_OUT_FREE: cond_ok = out_free;
      default:             cond_ok = 1'b1;
    endcase
  end

  always_comb begin
    pc_nxt        = cond_ok ? cw.tgt : cw.alt;
    req_nxt       = req_r;
    value_nxt     = value_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    ptr_nxt       = ptr_r;
    k_nxt         = k_r;
    rd_valid_nxt  = rd_en;
    found_nxt     = found_r;
    rej_nxt       = rej_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_found_nxt = out_found_r;
    out_rej_nxt   = out_rej_r;
    out_len_nxt   = out_len_r;

    if (cw.cond == dws_pkg::C_DISPATCH) begin
      pc_nxt = disp_tgt;
    end

    // compare happens in the cycle after the read
    if (rd_valid_r && (rd_data_r == value_r)) begin
      found_nxt = 1'b1;
    end

    case (cw.op)
      dws_pkg::OP_LATCH: begin
        if (in_acc) begin
          req_nxt   = in_req.req_type;
          value_nxt = in_req.value;
          found_nxt = 1'b0;
          rej_nxt   = 1'b0;
        end
      end
      dws_pkg::OP_DISP: begin
        rej_nxt = is_insert && full;
      end
      dws_pkg::OP_WR_FRONT: begin
        head_nxt  = head_dec;
        count_nxt = count_r + 1'b1;
      end
      dws_pkg::OP_WR_BACK: begin
        count_nxt = count_r + 1'b1;
      end
      dws_pkg::OP_SRCH_INIT: begin
        ptr_nxt = head_r;
        k_nxt   = '0;
      end
      dws_pkg::OP_SRCH_READ: begin
        ptr_nxt = ptr_inc;
        k_nxt   = k_inc;
      end
      dws_pkg::OP_EMIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = found_r;
          out_rej_nxt   = rej_r;
          out_len_nxt   = dws_pkg::LEN_W'(count_r);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= dws_pkg::STEP_WAIT;
      head_r      <= '0;
      count_r     <= '0;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r       <= req_nxt;
    value_r     <= value_nxt;
    ptr_r       <= ptr_nxt;
    k_r         <= k_nxt;
    found_r     <= found_nxt;
    rej_r       <= rej_nxt;
    out_found_r <= out_found_nxt;
    out_rej_r   <= out_rej_nxt;
    out_len_r   <= out_len_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= value_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[ptr_r];
    end
  end

  assign out_rsp.valid    = out_valid_r;
  assign out_rsp.found    = out_found_r;
  assign out_rsp.rejected = out_rej_r;
  assign out_rsp.length   = out_len_r;

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count above depth");

  a_write_grows: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |=> count_r == $past(count_r) + 1'b1)
    else $error("store write without count increment");

  // checked as the result is loaded; a held result may outlive the next request
  a_reject_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cw.op == dws_pkg::OP_EMIT) && out_free && rej_r |-> full && !found_r)
    else $error("rejected result while store not full");

  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> pc_r == dws_pkg::STEP_DISP && !rd_valid_r)
    else $error("accepted request not dispatched");
`endif

endmodule

### dv/dws_check_pkg.sv
package dws_check_pkg;
  import dws_pkg::*;

  // request code that the block must treat as a no-op
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic             found;
    logic             rejected;
    logic [LEN_W-1:0] length;
  } rsp_t;

  class deque_shadow;
    logic [VAL_W-1:0] slot [DEPTH_DEF];
    int               head;
    int               fill;
    rsp_t             expected_rsp [$];
    int               errors;
    int               requests;
    int               searches;
    int               hits;
    int               rejects;
    int               unused_codes;

    function new();
      head         = 0;
      fill         = 0;
      errors       = 0;
      requests     = 0;
      searches     = 0;
      hits         = 0;
      rejects      = 0;
      unused_codes = 0;
    endfunction

    // shadow update for one accepted request, queues the response it should cause
    function void note_request(logic [REQ_W-1:0] req, logic [VAL_W-1:0] val);
      rsp_t r;
      r = '0;
      requests++;
      case (req)
        REQ_FRONT, REQ_BACK: begin
          if (fill >= DEPTH_DEF) begin
            r.rejected = 1'b1;
            rejects++;
          end else if (req == REQ_FRONT) begin
            head       = (head + DEPTH_DEF - 1) % DEPTH_DEF;
            slot[head] = val;
            fill++;
          end else begin
            slot[(head + fill) % DEPTH_DEF] = val;
            fill++;
          end
        end
        REQ_SEARCH: begin
          searches++;
          // only written slots are scanned
          for (int k = 0; k < fill; k++) begin
            if (slot[(head + k) % DEPTH_DEF] == val) r.found = 1'b1;
          end
          if (r.found) hits++;
        end
        default: begin
          unused_codes++;
        end
      endcase
      r.length = fill[LEN_W-1:0];
      expected_rsp.push_back(r);
    endfunction

    function void check_response(rsp_t got, real t_ns);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        $display("%0.1f ns: response with none outstanding: found=%0b rejected=%0b length=%0d",
                 t_ns, got.found, got.rejected, got.length);
        errors++;
        return;
      end
      want = expected_rsp.pop_front();
      if (got.found !== want.found) begin
        $display("%0.1f ns: found expected %0b actual %0b", t_ns, want.found, got.found);
        errors++;
      end
      if (got.rejected !== want.rejected) begin
        $display("%0.1f ns: rejected expected %0b actual %0b", t_ns, want.rejected,
                 got.rejected);
        errors++;
      end
      if (got.length !== want.length) begin
        $display("%0.1f ns: length expected %0d actual %0d", t_ns, want.length, got.length);
        errors++;
      end
    endfunction
  endclass

endpackage

### dv/deque_with_search_unit_test.sv
module deque_with_search_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dws_pkg::*;
  import dws_check_pkg::*;

  localparam int RAND_ITEMS  = 1700;
  localparam int QUIET_ITEMS = 200;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = 40;

  logic clk = 1'b0;
  logic rst_n;
  bit   idle_on;
  int   cycles;
  int   stall_left;

  deque_shadow sb;

  dws_in_if  in_req ();
  dws_out_if out_rsp ();

  deque_with_search_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_req),
    .out_rsp (out_rsp)
  );

  always #6 clk = ~clk;

  initial begin
    rst_n            <= 1'b0;
    in_req.valid     <= 1'b0;
    in_req.req_type  <= REQ_FRONT;
    in_req.value     <= '0;
    out_rsp.ready    <= 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("deque_with_search_unit: mismatch");
      $finish;
    end
  end

  // response side: check on handshake, random stall bursts
  initial begin
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_rsp.valid && out_rsp.ready) begin
        sb.check_response('{out_rsp.found, out_rsp.rejected, out_rsp.length}, $realtime);
      end
      if (stall_left == 0 && idle_on && $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 6);
      end
      if (stall_left > 0) begin
        out_rsp.ready <= 1'b0;
        stall_left--;
      end else begin
        out_rsp.ready <= 1'b1;
      end
    end
  end

  task automatic send_req(logic [REQ_W-1:0] req, logic [VAL_W-1:0] val);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_req.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_req.valid    <= 1'b1;
    in_req.req_type <= req;
    in_req.value    <= val;
    do @(posedge clk); while (!in_req.ready);
    sb.note_request(req, val);
  endtask

  initial begin
    logic [REQ_W-1:0] req;
    logic [VAL_W-1:0] val;
    logic [VAL_W-1:0] stored;
    int               pick;

    sb      = new();
    cycles  = 0;
    idle_on = 1'b1;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: empty store, extremes, fill to full, rejects at full
    send_req(REQ_SEARCH, 32'h0000_0000);
    send_req(REQ_UNUSED, 32'hFFFF_FFFF);
    send_req(REQ_FRONT, 32'h8000_0000);
    send_req(REQ_BACK, 32'h7FFF_FFFF);
    send_req(REQ_SEARCH, 32'h8000_0000);
    send_req(REQ_SEARCH, 32'h7FFF_FFFF);
    send_req(REQ_SEARCH, 32'hFFFF_FFFF);
    for (int k = 0; k < DEPTH_DEF - 2; k++) begin
      send_req((k % 2 == 0) ? REQ_FRONT : REQ_BACK, $urandom);
    end
    send_req(REQ_FRONT, 32'h1234_5678);
    send_req(REQ_BACK, 32'h8765_4321);
    send_req(REQ_SEARCH, sb.slot[(sb.head + sb.fill - 1) % DEPTH_DEF]);
    send_req(REQ_UNUSED, 32'h0000_0000);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 150 == 0) idle_on = ($urandom_range(0, 3) != 0);
      if (n >= RAND_ITEMS - QUIET_ITEMS) idle_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 25) req = REQ_FRONT;
      else if (pick < 50) req = REQ_BACK;
      else if (pick < 88) req = REQ_SEARCH;
      else req = REQ_UNUSED;
      val = $urandom;
      if (req == REQ_SEARCH && sb.fill > 0) begin
        stored = sb.slot[(sb.head + $urandom_range(0, sb.fill - 1)) % DEPTH_DEF];
        pick = $urandom_range(0, 9);
        // half hits, some near misses one bit away
        if (pick < 5) val = stored;
        else if (pick < 7) val = stored ^ (32'd1 << $urandom_range(0, 31));
      end
      send_req(req, val);
    end
    in_req.valid <= 1'b0;

    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("ran %0d requests: %0d searches with %0d hits, %0d inserts rejected when full",
             sb.requests, sb.searches, sb.hits, sb.rejects);
    $display("%0d unused request codes, final length %0d", sb.unused_codes, sb.fill);
    if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
      $display("deque_with_search_unit: match");
    end else begin
      $display("deque_with_search_unit: mismatch");
    end
    $finish;
  end

endmodule
